FILE: sv/lrukv_pkg.sv
// Shared constants and types for the LRU key-value cache.
package lrukv_pkg;

  // Capacity register layout
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // APB register indexes (byte address / 4)
  localparam logic REG_CAPACITY = 1'b0;

  // Request codes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // Returned on a get miss and on every put
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Per-item decision from the directory
  typedef struct packed {
    logic hit;      // key present before this item
    logic evicted;  // least recent entry replaced
    logic write;    // data RAM write at the chosen slot
    logic read;     // data RAM read at the chosen slot
  } dir_status_t;

endpackage

FILE: sv/lrukv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrukv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/lrukv_dir.sv
// Key directory: parallel key match, valid bits, LRU ages and fill count.
module lrukv_dir
  import lrukv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         clear,
  input  logic [CAP_W-1:0]                             capacity,
  input  logic                                         go,
  input  logic                                         func,
  input  logic [31:0]                                  key,
  output dir_status_t                                  status,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] slot
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [31:0]      keys  [ENTRIES];
  logic [AGE_W-1:0] ages  [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0] fill_count;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [IDX_W-1:0] found_idx, victim_idx, free_idx;
  logic             free_any, victim_any;
  logic [AGE_W-1:0] hit_age;
  logic [CNT_W-1:0] fill_m1;
  logic [CMP_W-1:0] eff_cap;
  logic             full;

  // capacity zero acts as one, above ENTRIES saturates
  always_comb begin
    eff_cap = CMP_W'(capacity);
    if (eff_cap == '0) begin
      eff_cap = CMP_W'(1);
    end else if (eff_cap > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end

  assign fill_m1 = fill_count - 1'b1;
  assign full    = CMP_W'(fill_count) >= eff_cap;

  // oldest valid entry always holds age fill_count-1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (keys[i] == key);
      victim[i] = valid[i] && (ages[i] == fill_m1[AGE_W-1:0]);
    end
  end

  always_comb begin
    found_idx  = '0;
    victim_idx = '0;
    free_idx   = '0;
    free_any   = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_idx = IDX_W'(i);
      end
      if (victim[i]) begin
        victim_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign victim_any = |victim;
  assign hit_age    = ages[found_idx];

  always_comb begin
    status = '0;
    slot   = found_idx;
    if (|match) begin
      status.hit   = 1'b1;
      status.write = (func == FUNC_PUT);
      status.read  = (func == FUNC_GET);
    end else if (func == FUNC_PUT) begin
      if (full) begin
        slot           = victim_idx;
        status.evicted = victim_any;
        status.write   = victim_any;
      end else begin
        slot         = free_idx;
        status.write = free_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      fill_count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ages[i] <= '0;
      end
    end else if (clear) begin
      valid      <= '0;
      fill_count <= '0;
    end else if (go) begin
      if (status.hit) begin
        // touch: younger entries age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && (ages[i] < hit_age)) begin
            ages[i] <= AGE_W'(ages[i] + 1'b1);
          end
        end
        ages[found_idx] <= '0;
      end else if (status.write) begin
        // every other valid entry ages; the chosen slot restarts at zero
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && (IDX_W'(i) != slot)) begin
            ages[i] <= AGE_W'(ages[i] + 1'b1);
          end
        end
        ages[slot]  <= '0;
        valid[slot] <= 1'b1;
        keys[slot]  <= key;
        if (!status.evicted) begin
          fill_count <= CNT_W'(fill_count + 1'b1);
        end
      end
    end
  end

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    fill_count == CNT_W'($countones(valid)))
    else $error("fill count out of step with valid bits");

  a_keys_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key held by more than one valid entry");

  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    status.evicted |-> full && !status.hit)
    else $error("eviction without a full store");

endmodule

FILE: sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
//
// Fully associative key-value cache with least-recently-used replacement.
// Each item is a get (func 0) or a put (func 1) with a 32-bit key and, for a
// put, a 32-bit value. Every item yields exactly one result: hit tells
// whether the key was present, read_value carries the stored value on a get
// hit and all ones otherwise, evicted flags a put that displaced the least
// recent entry. One item is accepted per cycle while in_stall is low; each
// passes through the input register (key match, age update and data RAM access)
// and then the result register. The throughput is set by the parallel key
// compare and age update over all ENTRIES entries. in_stall rises only while
// a finished result is held by out_stall and the input register is full.
// Capacity sits at APB byte address 0 (5 bits, reset 16, zero acts as one,
// values above ENTRIES saturate); any write to it empties the cache and must
// be done while the block is idle. Stored values live in a small RAM, keys,
// valid bits and ages in flops.
module lru_key_value_cache
  import lrukv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] key,
  input  logic [31:0] value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] read_value,
  output logic        evicted
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // config
  logic [CAP_W-1:0] capacity;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

  // input register
  logic        in_full;
  logic        func_q;
  logic [31:0] key_q;
  logic [31:0] value_q;
  logic        advance;
  logic        go;

  // result stage moves when empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign go       = in_full && advance;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q  <= func;
      key_q   <= key;
      value_q <= value;
    end
  end

  // directory and data store
  dir_status_t      st;
  logic [IDX_W-1:0] slot;
  logic [31:0]      ram_rdata;

  lrukv_dir #(
    .ENTRIES(ENTRIES)
  ) u_dir (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_wr),
    .capacity(capacity),
    .go      (go),
    .func    (func_q),
    .key     (key_q),
    .status  (st),
    .slot    (slot)
  );

  // read data register only moves with the pipeline, so it holds while stalled
  lrukv_ram #(
    .WIDTH(32),
    .DEPTH(ENTRIES)
  ) u_data (
    .clk  (clk),
    .we   (go && st.write),
    .waddr(slot),
    .wdata(value_q),
    .re   (go && st.read),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  // result register
  logic rd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hit     <= st.hit;
      evicted <= st.evicted;
      rd_q    <= st.read;
    end
  end

  assign read_value = rd_q ? ram_rdata : MISS_VALUE;

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result stage free");

  a_hit_evict_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and eviction on one item");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == MISS_VALUE)
    else $error("miss returned a stored value");

endmodule
